// ===== sv/mlr_pkg.sv =====
package mlr_pkg;

   // Default coordinate width of the endpoint and pixel fields.
   localparam int COORD_BITS_DEF = 11;

   // Command codes carried by a request item.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_NEXT  = 1'b1;

   // Zone codes for the eight symmetric regions of a line.
   localparam logic [2:0] ZONE_0 = 3'd0;
   localparam logic [2:0] ZONE_1 = 3'd1;
   localparam logic [2:0] ZONE_2 = 3'd2;
   localparam logic [2:0] ZONE_3 = 3'd3;
   localparam logic [2:0] ZONE_4 = 3'd4;
   localparam logic [2:0] ZONE_5 = 3'd5;
   localparam logic [2:0] ZONE_6 = 3'd6;
   localparam logic [2:0] ZONE_7 = 3'd7;

endpackage

// ===== sv/mlr_req_if.sv =====
interface mlr_req_if #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== sv/mlr_rsp_if.sv =====
interface mlr_rsp_if #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         pixel_valid;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic [2:0]                   octant_zone;
   logic                         last_pixel;

   modport source (output valid, pixel_valid, pixel_x, pixel_y, octant_zone, last_pixel,
                   input ready);
   modport sink (input valid, pixel_valid, pixel_x, pixel_y, octant_zone, last_pixel,
                 output ready);
endinterface

// ===== sv/mlr_zone_map.sv =====
module mlr_zone_map #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic [2:0]                   zone,
   output logic signed [COORD_BITS:0]   zone_x0,
   output logic signed [COORD_BITS:0]   zone_y0,
   output logic signed [COORD_BITS:0]   zone_x1,
   output logic signed [COORD_BITS+2:0] decision,
   output logic signed [COORD_BITS+2:0] step_east,
   output logic signed [COORD_BITS+2:0] step_diagonal
);
   import mlr_pkg::*;

   localparam int WW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 3;

   logic signed [WW-1:0] sx, sy, ex, ey;
   logic signed [WW-1:0] dx, dy, adx, ady;
   logic                 wide;
   logic signed [WW-1:0] zy1;
   logic signed [DW-1:0] zdx, zdy;

   // Map one point into zone 0 by swaps and sign changes.
   function automatic void to_zone0(input logic [2:0] z,
                                    input logic signed [WW-1:0] x,
                                    input logic signed [WW-1:0] y,
                                    output logic signed [WW-1:0] zx,
                                    output logic signed [WW-1:0] zy);
      case (z)
         ZONE_0: begin zx = x;  zy = y;  end
         ZONE_1: begin zx = y;  zy = x;  end
         ZONE_2: begin zx = y;  zy = -x; end
         ZONE_3: begin zx = -x; zy = y;  end
         ZONE_4: begin zx = -x; zy = -y; end
         ZONE_5: begin zx = -y; zy = -x; end
         ZONE_6: begin zx = -y; zy = x;  end
         default: begin zx = x; zy = -y; end
      endcase
   endfunction

   // Widen the endpoints so that differences and negations cannot overflow.
   assign sx = WW'(start_x);
   assign sy = WW'(start_y);
   assign ex = WW'(end_x);
   assign ey = WW'(end_y);

   assign dx   = ex - sx;
   assign dy   = ey - sy;
   assign adx  = dx[WW-1] ? -dx : dx;
   assign ady  = dy[WW-1] ? -dy : dy;
   assign wide = adx > ady;

   // Zone choice by the signs of dx and dy; equal magnitudes pick the steep zone.
   always_comb begin
      if (dx > 0 && dy >= 0) begin
         zone = wide ? ZONE_0 : ZONE_1;
      end else if (dx <= 0 && dy > 0) begin
         zone = wide ? ZONE_3 : ZONE_2;
      end else if (dx < 0 && dy <= 0) begin
         zone = wide ? ZONE_4 : ZONE_5;
      end else begin
         zone = wide ? ZONE_7 : ZONE_6;
      end
   end

   always_comb begin
      to_zone0(zone, sx, sy, zone_x0, zone_y0);
      to_zone0(zone, ex, ey, zone_x1, zy1);
   end

   // Initial decision term and the two step increments.
   assign zdx           = DW'(zone_x1) - DW'(zone_x0);
   assign zdy           = DW'(zy1) - DW'(zone_y0);
   assign step_east     = zdy <<< 1;
   assign step_diagonal = (zdy - zdx) <<< 1;
   assign decision      = (zdy <<< 1) - zdx;

endmodule

// ===== sv/mlr_walker.sv =====
module mlr_walker #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_go,
   input  logic                         is_start,
   input  logic [2:0]                   setup_zone,
   input  logic signed [COORD_BITS:0]   setup_x0,
   input  logic signed [COORD_BITS:0]   setup_y0,
   input  logic signed [COORD_BITS:0]   setup_x1,
   input  logic signed [COORD_BITS+2:0] setup_decision,
   input  logic signed [COORD_BITS+2:0] setup_east,
   input  logic signed [COORD_BITS+2:0] setup_diagonal,
   output logic                         pixel_valid,
   output logic signed [COORD_BITS-1:0] pixel_x,
   output logic signed [COORD_BITS-1:0] pixel_y,
   output logic [2:0]                   octant_zone,
   output logic                         last_pixel
);
   import mlr_pkg::*;

   localparam int WW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 3;

   logic                 active_ff, active_in;
   logic signed [WW-1:0] walk_x_ff, walk_x_in;
   logic signed [WW-1:0] walk_y_ff, walk_y_in;
   logic signed [WW-1:0] walk_end_x_ff, walk_end_x_in;
   logic signed [DW-1:0] decision_ff, decision_in;
   logic signed [DW-1:0] step_east_ff, step_east_in;
   logic signed [DW-1:0] step_diagonal_ff, step_diagonal_in;
   logic [2:0]           line_zone_ff, line_zone_in;

   logic                 last;
   logic signed [WW-1:0] map_x, map_y;

   // Map a zone-0 point back to the line's own orientation.
   function automatic void from_zone0(input logic [2:0] z,
                                      input logic signed [WW-1:0] zx,
                                      input logic signed [WW-1:0] zy,
                                      output logic signed [WW-1:0] x,
                                      output logic signed [WW-1:0] y);
      case (z)
         ZONE_0: begin x = zx;  y = zy;  end
         ZONE_1: begin x = zy;  y = zx;  end
         ZONE_2: begin x = -zy; y = zx;  end
         ZONE_3: begin x = -zx; y = zy;  end
         ZONE_4: begin x = -zx; y = -zy; end
         ZONE_5: begin x = -zy; y = -zx; end
         ZONE_6: begin x = zy;  y = -zx; end
         default: begin x = zx; y = -zy; end
      endcase
   endfunction

   // Current point: the setup of a new line, or one midpoint step on the old one.
   always_comb begin
      if (is_start) begin
         walk_x_in        = setup_x0;
         walk_y_in        = setup_y0;
         walk_end_x_in    = setup_x1;
         decision_in      = setup_decision;
         step_east_in     = setup_east;
         step_diagonal_in = setup_diagonal;
         line_zone_in     = setup_zone;
      end else begin
         walk_x_in        = walk_x_ff + WW'(1);
         walk_end_x_in    = walk_end_x_ff;
         step_east_in     = step_east_ff;
         step_diagonal_in = step_diagonal_ff;
         line_zone_in     = line_zone_ff;
         if (decision_ff < 0) begin
            walk_y_in   = walk_y_ff;
            decision_in = decision_ff + step_east_ff;
         end else begin
            walk_y_in   = walk_y_ff + WW'(1);
            decision_in = decision_ff + step_diagonal_ff;
         end
      end
   end

   assign last = walk_x_in >= walk_end_x_in;

   always_comb begin
      from_zone0(line_zone_in, walk_x_in, walk_y_in, map_x, map_y);
   end

   // A next command with no line in progress gives an all-zero result.
   assign pixel_valid = is_start || active_ff;
   assign pixel_x     = pixel_valid ? map_x[COORD_BITS-1:0] : '0;
   assign pixel_y     = pixel_valid ? map_y[COORD_BITS-1:0] : '0;
   assign octant_zone = pixel_valid ? line_zone_in : ZONE_0;
   assign last_pixel  = pixel_valid && last;

   assign active_in = pixel_valid && !last;

   // Line state advances only when a pixel is produced.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         walk_x_ff        <= '0;
         walk_y_ff        <= '0;
         walk_end_x_ff    <= '0;
         decision_ff      <= '0;
         step_east_ff     <= '0;
         step_diagonal_ff <= '0;
         line_zone_ff     <= ZONE_0;
      end else if (step_go && pixel_valid) begin
         active_ff        <= active_in;
         walk_x_ff        <= walk_x_in;
         walk_y_ff        <= walk_y_in;
         walk_end_x_ff    <= walk_end_x_in;
         decision_ff      <= decision_in;
         step_east_ff     <= step_east_in;
         step_diagonal_ff <= step_diagonal_in;
         line_zone_ff     <= line_zone_in;
      end
   end

endmodule

// ===== sv/midpoint_line_rasterizer.sv =====
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   command, start_x, start_y, end_x, end_y
// rsp      out  valid/ready   pixel_valid, pixel_x, pixel_y, octant_zone, last_pixel
//
// One item per cycle while results are taken downstream; an accepted item passes through
// the input register, then the line step and zone mapping into the result register.
// Reset is synchronous and clears the valid flags and the line state; no line is active.
// A stalled result holds in the result register; the input register keeps taking an
// item whenever the result register can move on in the same cycle.
module midpoint_line_rasterizer #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   mlr_req_if.sink   req_chan,
   mlr_rsp_if.source rsp_chan
);
   import mlr_pkg::*;

   localparam int WW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 3;

   logic                         req_valid_ff, req_valid_in;
   logic                         req_command_ff;
   logic signed [COORD_BITS-1:0] req_start_x_ff, req_start_y_ff;
   logic signed [COORD_BITS-1:0] req_end_x_ff, req_end_y_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_pixel_valid_ff;
   logic signed [COORD_BITS-1:0] rsp_pixel_x_ff, rsp_pixel_y_ff;
   logic [2:0]                   rsp_zone_ff;
   logic                         rsp_last_ff;

   logic                         req_take, advance, fire;

   logic [2:0]                   setup_zone;
   logic signed [WW-1:0]         setup_x0, setup_y0, setup_x1;
   logic signed [DW-1:0]         setup_decision, setup_east, setup_diagonal;

   logic                         pix_valid, pix_last;
   logic signed [COORD_BITS-1:0] pix_x, pix_y;
   logic [2:0]                   pix_zone;

   // Handshake: the result register moves on when empty or taken downstream.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_valid_ff && advance;
   assign req_chan.ready = !req_valid_ff || fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign req_valid_in = req_take || (req_valid_ff && !fire);
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_command_ff <= req_chan.command;
         req_start_x_ff <= req_chan.start_x;
         req_start_y_ff <= req_chan.start_y;
         req_end_x_ff   <= req_chan.end_x;
         req_end_y_ff   <= req_chan.end_y;
      end
   end

   mlr_zone_map #(
      .COORD_BITS (COORD_BITS)
   ) u_zone_map (
      .start_x       (req_start_x_ff),
      .start_y       (req_start_y_ff),
      .end_x         (req_end_x_ff),
      .end_y         (req_end_y_ff),
      .zone          (setup_zone),
      .zone_x0       (setup_x0),
      .zone_y0       (setup_y0),
      .zone_x1       (setup_x1),
      .decision      (setup_decision),
      .step_east     (setup_east),
      .step_diagonal (setup_diagonal)
   );

   mlr_walker #(
      .COORD_BITS (COORD_BITS)
   ) u_walker (
      .clock          (clock),
      .reset          (reset),
      .step_go        (fire),
      .is_start       (req_command_ff == CMD_START),
      .setup_zone     (setup_zone),
      .setup_x0       (setup_x0),
      .setup_y0       (setup_y0),
      .setup_x1       (setup_x1),
      .setup_decision (setup_decision),
      .setup_east     (setup_east),
      .setup_diagonal (setup_diagonal),
      .pixel_valid    (pix_valid),
      .pixel_x        (pix_x),
      .pixel_y        (pix_y),
      .octant_zone    (pix_zone),
      .last_pixel     (pix_last)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_pixel_valid_ff <= pix_valid;
         rsp_pixel_x_ff     <= pix_x;
         rsp_pixel_y_ff     <= pix_y;
         rsp_zone_ff        <= pix_zone;
         rsp_last_ff        <= pix_last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_valid = rsp_pixel_valid_ff;
   assign rsp_chan.pixel_x     = rsp_pixel_x_ff;
   assign rsp_chan.pixel_y     = rsp_pixel_y_ff;
   assign rsp_chan.octant_zone = rsp_zone_ff;
   assign rsp_chan.last_pixel  = rsp_last_ff;

endmodule
